// File: design/aao_pkg.sv
// Package with the shared widths, constants and types of the arbitrary axis transform.
`default_nettype none
package aao_pkg;
    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int MANT_BITS  = 30;
    localparam int NIN_W      = 48;
    localparam int BL_W       = 6;
    localparam int UNIT_W     = FRAC_BITS + 2;
    localparam int QUO_W      = FRAC_BITS + 1;
    localparam int SUM_W      = 2 * MANT_BITS + 2;
    localparam int SQ_W       = 64;
    localparam int ROOT_W     = MANT_BITS + 2;
    localparam int SQ_STAGES  = SQ_W / 2;
    localparam int DIV_STAGES = QUO_W;
    localparam int NUM_W      = MANT_BITS + FRAC_BITS + 1;
    localparam int REM_W      = NUM_W + 1;
    localparam int CROSS_W    = MANT_BITS + UNIT_W + 1;
    localparam int SIDE_W     = 3 * UNIT_W + 6 * COORD_BITS;
    localparam int THRESH     = 1 << (FRAC_BITS - 6);
    localparam int PA_W       = UNIT_W + COORD_BITS;
    localparam int PC_W       = 2 * COORD_BITS;
    localparam int ACC_W      = PC_W + 2;
    localparam int SHR_W      = ACC_W - FRAC_BITS;

    typedef logic [2:0][NIN_W-1:0]      nmag_t;
    typedef logic [2:0][MANT_BITS-1:0]  pmag_t;
    typedef logic [2:0][UNIT_W-1:0]     unit_t;
    typedef logic [2:0][COORD_BITS-1:0] coord_t;
    typedef logic [SIDE_W-1:0]          side_t;
endpackage
`default_nettype wire

// File: design/aao_prescale.sv
// Three stage prescaler that brings the largest magnitude of a vector to a fixed bit length.
`default_nettype none
module aao_prescale (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  wire aao_pkg::nmag_t in_mag,
    input  wire logic [2:0]     in_sign,
    input  wire aao_pkg::side_t in_side,
    output logic                out_valid,
    output aao_pkg::pmag_t      out_mag,
    output logic [2:0]          out_sign,
    output aao_pkg::side_t      out_side
);
    import aao_pkg::*;

    logic             v1_reg, v2_reg, v3_reg;
    nmag_t            mag1_reg, mag2_reg;
    logic [NIN_W-1:0] max1_reg, max_next;
    logic [2:0]       sg1_reg, sg2_reg, sg3_reg;
    side_t            sd1_reg, sd2_reg, sd3_reg;
    logic [BL_W-1:0]  bl2_reg, bl_next;
    pmag_t            mag3_reg, mag3_next;
    logic [NIN_W+MANT_BITS-1:0] wide;

    always_comb begin
        max_next = in_mag[0];
        if (in_mag[1] > max_next) max_next = in_mag[1];
        if (in_mag[2] > max_next) max_next = in_mag[2];
    end

    always_comb begin
        bl_next = '0;
        for (int i = 0; i < NIN_W; i++) begin
            if (max1_reg[i]) bl_next = BL_W'(i + 1);
        end
    end

    always_comb begin
        wide = '0;
        for (int i = 0; i < 3; i++) begin
            wide = {mag2_reg[i], {MANT_BITS{1'b0}}} >> bl2_reg;
            mag3_next[i] = wide[MANT_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag1_reg <= in_mag;
            max1_reg <= max_next;
            sg1_reg  <= in_sign;
            sd1_reg  <= in_side;
            mag2_reg <= mag1_reg;
            bl2_reg  <= bl_next;
            sg2_reg  <= sg1_reg;
            sd2_reg  <= sd1_reg;
            mag3_reg <= mag3_next;
            sg3_reg  <= sg2_reg;
            sd3_reg  <= sd2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_mag   = mag3_reg;
    assign out_sign  = sg3_reg;
    assign out_side  = sd3_reg;
endmodule
`default_nettype wire

// File: design/aao_normalize.sv
// Pipelined vector normalizer: prescale, sum of squares, square root and division stages.
`default_nettype none
module aao_normalize (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  wire aao_pkg::nmag_t in_mag,
    input  wire logic [2:0]     in_sign,
    input  wire aao_pkg::side_t in_side,
    output logic                out_valid,
    output aao_pkg::unit_t      out_unit,
    output aao_pkg::side_t      out_side
);
    import aao_pkg::*;

    typedef struct packed {
        logic            v;
        logic            z;
        pmag_t           mg;
        logic [2:0]      sg;
        side_t           side;
        logic [SQ_W-1:0] x;
        logic [SQ_W-1:0] res;
    } sq_t;

    typedef struct packed {
        logic                        v;
        logic                        z;
        logic [2:0]                  sg;
        side_t                       side;
        logic [ROOT_W-1:0]           len;
        logic [2:0][REM_W-1:0]       rem;
        logic [2:0][QUO_W-1:0]       q;
    } dv_t;

    logic       pv;
    pmag_t      pmag;
    logic [2:0] psg;
    side_t      pside;

    aao_prescale u_pre (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(in_valid), .in_mag(in_mag), .in_sign(in_sign), .in_side(in_side),
        .out_valid(pv), .out_mag(pmag), .out_sign(psg), .out_side(pside)
    );

    logic                       n1v_reg;
    pmag_t                      n1mg_reg;
    logic [2:0]                 n1sg_reg;
    side_t                      n1sd_reg;
    logic [2:0][2*MANT_BITS-1:0] n1sq_reg;
    sq_t                        sq_reg [SQ_STAGES+1];
    sq_t                        sq_first;
    dv_t                        dv_reg [DIV_STAGES+1];
    dv_t                        dv_first;
    logic                       ov_reg;
    unit_t                      ou_reg, ou_next;
    side_t                      osd_reg;

    always_comb begin
        sq_first      = '0;
        sq_first.v    = n1v_reg;
        sq_first.mg   = n1mg_reg;
        sq_first.sg   = n1sg_reg;
        sq_first.side = n1sd_reg;
        sq_first.x    = SQ_W'({2'b00, n1sq_reg[0]}) + SQ_W'({2'b00, n1sq_reg[1]})
                      + SQ_W'({2'b00, n1sq_reg[2]});
        sq_first.z    = (sq_first.x == '0);
        sq_first.res  = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n1v_reg      <= 1'b0;
            sq_reg[0].v  <= 1'b0;
        end else if (en) begin
            n1v_reg      <= pv;
            sq_reg[0]    <= sq_first;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n1mg_reg <= pmag;
            n1sg_reg <= psg;
            n1sd_reg <= pside;
            for (int i = 0; i < 3; i++) begin
                n1sq_reg[i] <= pmag[i] * pmag[i];
            end
        end
    end

    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
        sq_t nxt;
        logic [SQ_W-1:0] t;
        always_comb begin
            nxt = sq_reg[k];
            t   = sq_reg[k].res + BIT;
            if (sq_reg[k].x >= t) begin
                nxt.x   = sq_reg[k].x - t;
                nxt.res = (sq_reg[k].res >> 1) + BIT;
            end else begin
                nxt.res = sq_reg[k].res >> 1;
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_reg[k+1].v <= 1'b0;
            end else if (en) begin
                sq_reg[k+1] <= nxt;
            end
        end
    end

    always_comb begin
        dv_first      = '0;
        dv_first.v    = sq_reg[SQ_STAGES].v;
        dv_first.z    = sq_reg[SQ_STAGES].z;
        dv_first.sg   = sq_reg[SQ_STAGES].sg;
        dv_first.side = sq_reg[SQ_STAGES].side;
        dv_first.len  = sq_reg[SQ_STAGES].res[ROOT_W-1:0];
        for (int i = 0; i < 3; i++) begin
            dv_first.rem[i] = REM_W'({sq_reg[SQ_STAGES].mg[i], {FRAC_BITS{1'b0}}})
                            + REM_W'(dv_first.len >> 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg[0].v <= 1'b0;
        end else if (en) begin
            dv_reg[0] <= dv_first;
        end
    end

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        dv_t nxt;
        logic [REM_W-1:0] d;
        always_comb begin
            nxt = dv_reg[k];
            d   = REM_W'(dv_reg[k].len) << (DIV_STAGES - 1 - k);
            for (int i = 0; i < 3; i++) begin
                if (dv_reg[k].rem[i] >= d) begin
                    nxt.rem[i] = dv_reg[k].rem[i] - d;
                    nxt.q[i][DIV_STAGES-1-k] = 1'b1;
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[k+1].v <= 1'b0;
            end else if (en) begin
                dv_reg[k+1] <= nxt;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (dv_reg[DIV_STAGES].z) begin
                ou_next[i] = '0;
            end else if (dv_reg[DIV_STAGES].sg[i]) begin
                ou_next[i] = UNIT_W'(0) - UNIT_W'(dv_reg[DIV_STAGES].q[i]);
            end else begin
                ou_next[i] = UNIT_W'(dv_reg[DIV_STAGES].q[i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (en) begin
            ov_reg <= dv_reg[DIV_STAGES].v;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ou_reg  <= ou_next;
            osd_reg <= dv_reg[DIV_STAGES].side;
        end
    end

    assign out_valid = ov_reg;
    assign out_unit  = ou_reg;
    assign out_side  = osd_reg;
endmodule
`default_nettype wire

// File: design/aao_world.sv
// Three stage world point stage: products, rounded sum and saturation.
`default_nettype none
module aao_world (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire aao_pkg::unit_t  ax,
    input  wire aao_pkg::unit_t  ay,
    input  wire aao_pkg::coord_t nrm,
    input  wire aao_pkg::coord_t pnt,
    output logic                 out_valid,
    output aao_pkg::coord_t      world,
    output logic                 sat
);
    import aao_pkg::*;

    localparam logic signed [SHR_W-1:0] MAXV = SHR_W'((64'(1) << (COORD_BITS - 1)) - 1);
    localparam logic signed [SHR_W-1:0] MINV = -MAXV - SHR_W'(1);

    logic                          v1_reg, v2_reg, v3_reg;
    logic signed [2:0][PA_W-1:0]   pa_reg, pb_reg;
    logic signed [2:0][PC_W-1:0]   pc_reg;
    logic [2:0][SHR_W-1:0]         sh_reg, sh_next;
    coord_t                        w_reg, w_next;
    logic                          sat_reg, sat_next;
    logic signed [ACC_W-1:0]       acc;

    always_comb begin
        acc = '0;
        for (int i = 0; i < 3; i++) begin
            acc = ACC_W'($signed(pa_reg[i])) + ACC_W'($signed(pb_reg[i]))
                + ACC_W'($signed(pc_reg[i])) + ACC_W'(1 << (FRAC_BITS - 1));
            sh_next[i] = SHR_W'(acc >>> FRAC_BITS);
        end
    end

    always_comb begin
        sat_next = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if ($signed(sh_reg[i]) > MAXV) begin
                w_next[i] = COORD_BITS'(MAXV);
                sat_next  = 1'b1;
            end else if ($signed(sh_reg[i]) < MINV) begin
                w_next[i] = COORD_BITS'(MINV);
                sat_next  = 1'b1;
            end else begin
                w_next[i] = sh_reg[i][COORD_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                pa_reg[i] <= $signed(ax[i]) * $signed(pnt[0]);
                pb_reg[i] <= $signed(ay[i]) * $signed(pnt[1]);
                pc_reg[i] <= $signed(nrm[i]) * $signed(pnt[2]);
            end
            sh_reg  <= sh_next;
            w_reg   <= w_next;
            sat_reg <= sat_next;
        end
    end

    assign out_valid = v3_reg;
    assign world     = w_reg;
    assign sat       = sat_reg;
endmodule
`default_nettype wire

// File: design/arbitrary_axis_ocs_to_wcs_unit.sv
// Throughput: one item per cycle until a full output buffer stalls the input; the two
// normalizer pipelines (one square root bit and one quotient bit per stage) and the
// product stages all advance together.
// A two entry output buffer lets the pipeline keep moving while a result waits.
// Reset (synchronous, active low) clears all valid bits; data registers are not reset.
// Top level of the arbitrary axis transform from object to world coordinates.
`default_nettype none
module arbitrary_axis_ocs_to_wcs_unit (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // normal_x, normal_y, normal_z, point_x, point_y, point_z, 32 bits each
    input  wire logic [191:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // world_x, world_y, world_z, 32 bits each
    output logic [95:0]       m_tdata,
    // saturated
    output logic [0:0]        m_tuser
);
    import aao_pkg::*;

    logic   en;
    logic   skid_v_reg;
    coord_t n_in, p_in;
    nmag_t  ax_mag;
    logic [2:0] ax_sg;
    logic [2:0][COORD_BITS:0] nabs;
    logic   near_pole;

    assign en = ~skid_v_reg;
    assign s_tready = en;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_in[i] = s_tdata[i*COORD_BITS +: COORD_BITS];
            p_in[i] = s_tdata[(i+3)*COORD_BITS +: COORD_BITS];
            nabs[i] = n_in[i][COORD_BITS-1]
                    ? (COORD_BITS+1)'(0) - {1'b1, n_in[i]} : {1'b0, n_in[i]};
        end
        near_pole = (nabs[0] < (COORD_BITS+1)'(THRESH))
                 && (nabs[1] < (COORD_BITS+1)'(THRESH));
        if (near_pole) begin
            ax_mag = {NIN_W'(nabs[0]), NIN_W'(0), NIN_W'(nabs[2])};
            ax_sg  = {(~n_in[0][COORD_BITS-1]) & (n_in[0] != '0), 1'b0,
                      n_in[2][COORD_BITS-1]};
        end else begin
            ax_mag = {NIN_W'(0), NIN_W'(nabs[0]), NIN_W'(nabs[1])};
            ax_sg  = {1'b0, n_in[0][COORD_BITS-1],
                      (~n_in[1][COORD_BITS-1]) & (n_in[1] != '0)};
        end
    end

    logic   n1_v;
    unit_t  n1_ax;
    side_t  n1_sd;

    aao_normalize u_norm_x (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(s_tvalid & s_tready), .in_mag(ax_mag), .in_sign(ax_sg),
        .in_side({(3*UNIT_W)'(0), p_in, n_in}),
        .out_valid(n1_v), .out_unit(n1_ax), .out_side(n1_sd)
    );

    coord_t n1_n;
    nmag_t  ns_in;
    logic [2:0] ns_sg_in;

    always_comb begin
        n1_n = n1_sd[3*COORD_BITS-1:0];
        for (int i = 0; i < 3; i++) begin
            ns_sg_in[i] = n1_n[i][COORD_BITS-1];
            ns_in[i]    = ns_sg_in[i] ? NIN_W'(0) - NIN_W'($signed(n1_n[i]))
                                      : NIN_W'(n1_n[i]);
        end
    end

    logic   ps_v;
    pmag_t  ps_mg;
    logic [2:0] ps_sg;
    side_t  ps_sd;

    aao_prescale u_pre_n (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(n1_v), .in_mag(ns_in), .in_sign(ns_sg_in),
        .in_side({n1_ax, n1_sd[6*COORD_BITS-1:0]}),
        .out_valid(ps_v), .out_mag(ps_mg), .out_sign(ps_sg), .out_side(ps_sd)
    );

    logic signed [2:0][MANT_BITS:0] ns;
    unit_t ps_ax;
    logic signed [5:0][CROSS_W-1:0] cp_next;
    logic signed [5:0][CROSS_W-1:0] cp_reg;
    logic  c1v_reg, c2v_reg;
    side_t c1sd_reg, c2sd_reg;
    nmag_t ay_mag_reg, ay_mag_next;
    logic [2:0] ay_sg_reg, ay_sg_next;
    logic signed [CROSS_W-1:0] d;

    always_comb begin
        ps_ax = ps_sd[SIDE_W-1 -: 3*UNIT_W];
        for (int i = 0; i < 3; i++) begin
            ns[i] = ps_sg[i] ? (MANT_BITS+1)'(0) - (MANT_BITS+1)'(ps_mg[i])
                             : (MANT_BITS+1)'(ps_mg[i]);
        end
        cp_next[0] = $signed(ns[1]) * $signed(ps_ax[2]);
        cp_next[1] = $signed(ps_ax[1]) * $signed(ns[2]);
        cp_next[2] = $signed(ns[2]) * $signed(ps_ax[0]);
        cp_next[3] = $signed(ps_ax[2]) * $signed(ns[0]);
        cp_next[4] = $signed(ns[0]) * $signed(ps_ax[1]);
        cp_next[5] = $signed(ps_ax[0]) * $signed(ns[1]);
    end

    always_comb begin
        d = '0;
        for (int i = 0; i < 3; i++) begin
            d = $signed(cp_reg[2*i]) - $signed(cp_reg[2*i+1]);
            ay_sg_next[i]  = d[CROSS_W-1];
            ay_mag_next[i] = d[CROSS_W-1] ? NIN_W'(-d) : NIN_W'(d);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1v_reg <= 1'b0;
            c2v_reg <= 1'b0;
        end else if (en) begin
            c1v_reg <= ps_v;
            c2v_reg <= c1v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cp_reg     <= cp_next;
            c1sd_reg   <= ps_sd;
            ay_mag_reg <= ay_mag_next;
            ay_sg_reg  <= ay_sg_next;
            c2sd_reg   <= c1sd_reg;
        end
    end

    logic  n2_v;
    unit_t n2_ay;
    side_t n2_sd;

    aao_normalize u_norm_y (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(c2v_reg), .in_mag(ay_mag_reg), .in_sign(ay_sg_reg), .in_side(c2sd_reg),
        .out_valid(n2_v), .out_unit(n2_ay), .out_side(n2_sd)
    );

    logic   w_v, w_sat;
    coord_t w_pt;

    aao_world u_world (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(n2_v),
        .ax(n2_sd[SIDE_W-1 -: 3*UNIT_W]), .ay(n2_ay),
        .nrm(n2_sd[3*COORD_BITS-1:0]), .pnt(n2_sd[6*COORD_BITS-1:3*COORD_BITS]),
        .out_valid(w_v), .world(w_pt), .sat(w_sat)
    );

    logic        out_v_reg;
    logic [96:0] out_d_reg, skid_d_reg;
    logic        take;

    assign take = out_v_reg & m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (skid_v_reg) begin
            if (take) begin
                out_d_reg  <= skid_d_reg;
                skid_v_reg <= 1'b0;
            end
        end else if (w_v) begin
            if (!out_v_reg || take) begin
                out_d_reg <= {w_sat, w_pt};
                out_v_reg <= 1'b1;
            end else begin
                skid_d_reg <= {w_sat, w_pt};
                skid_v_reg <= 1'b1;
            end
        end else if (take) begin
            out_v_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_d_reg[95:0];
    assign m_tuser  = out_d_reg[96];
endmodule
`default_nettype wire

// File: design/aao_checker.sv
// Port level checker for the arbitrary axis transform, bound to the top level.
`default_nettype none
module aao_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic [191:0] s_tdata,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [95:0]  m_tdata,
    input wire logic [0:0]   m_tuser
);
    function automatic logic at_limit(input logic [31:0] w);
        return (w == 32'h7fffffff) || (w == 32'h80000000);
    endfunction

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_sat_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> at_limit(m_tdata[31:0]) || at_limit(m_tdata[63:32])
                                   || at_limit(m_tdata[95:64]))
        else $error("saturated item without a clamped component");

    a_ready_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result waiting");
endmodule

bind arbitrary_axis_ocs_to_wcs_unit aao_checker u_aao_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser)
);
`default_nettype wire

// File: bench/tb_checker.sv
// Checker that predicts each world point from the input items and compares the results.
`timescale 1ns / 100ps
module tb_checker (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [191:0] s_tdata,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [95:0]  m_tdata,
    input  wire logic [0:0]   m_tuser,
    output int                mismatches,
    output int                pending
);
    import aao_pkg::*;

    typedef struct packed {
        logic [COORD_BITS-1:0] wx;
        logic [COORD_BITS-1:0] wy;
        logic [COORD_BITS-1:0] wz;
        logic                  sat;
    } world_t;

    typedef longint vec3_t[3];

    world_t world_q[$];

    function automatic longint unsigned mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic void prescale_vec(input vec3_t v, output longint unsigned mg[3]);
        longint unsigned m;
        int bl;
        m = 0;
        for (int i = 0; i < 3; i++) begin
            mg[i] = mag(v[i]);
            if (mg[i] > m) m = mg[i];
        end
        bl = 0;
        while ((m >> bl) != 0) bl++;
        for (int i = 0; i < 3; i++) begin
            if (m == 0) mg[i] = 0;
            else if (bl > MANT_BITS) mg[i] = mg[i] >> (bl - MANT_BITS);
            else mg[i] = mg[i] << (MANT_BITS - bl);
        end
    endfunction

    function automatic longint unsigned root64(input longint unsigned x);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic void unit_vec(input vec3_t v, output vec3_t u);
        longint unsigned mg[3];
        longint unsigned sum, len, q;
        prescale_vec(v, mg);
        sum = mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2];
        len = root64(sum);
        for (int i = 0; i < 3; i++) begin
            if (sum == 0) begin
                u[i] = 0;
            end else begin
                q = ((mg[i] << FRAC_BITS) + (len >> 1)) / len;
                u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
            end
        end
    endfunction

    function automatic world_t predict_world(input logic [191:0] d);
        vec3_t n, p, axr, ax, ns, ayr, ay;
        longint unsigned mg[3];
        logic signed [127:0] acc, sh;
        logic [COORD_BITS-1:0] w[3];
        world_t r;
        r.sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            n[i] = longint'($signed(d[32*i +: 32]));
            p[i] = longint'($signed(d[96 + 32*i +: 32]));
        end
        if (mag(n[0]) < THRESH && mag(n[1]) < THRESH) begin
            axr[0] = n[2]; axr[1] = 0; axr[2] = -n[0];
        end else begin
            axr[0] = -n[1]; axr[1] = n[0]; axr[2] = 0;
        end
        unit_vec(axr, ax);
        prescale_vec(n, mg);
        for (int i = 0; i < 3; i++) ns[i] = (n[i] < 0) ? -longint'(mg[i]) : longint'(mg[i]);
        ayr[0] = ns[1] * ax[2] - ax[1] * ns[2];
        ayr[1] = ns[2] * ax[0] - ax[2] * ns[0];
        ayr[2] = ns[0] * ax[1] - ax[0] * ns[1];
        unit_vec(ayr, ay);
        for (int i = 0; i < 3; i++) begin
            acc = 128'(ax[i]) * 128'(p[0]) + 128'(ay[i]) * 128'(p[1])
                + 128'(n[i]) * 128'(p[2]) + (128'sd1 <<< (FRAC_BITS - 1));
            sh = acc >>> FRAC_BITS;
            if (sh > 128'sd2147483647) begin
                w[i] = 32'h7fff_ffff; r.sat = 1'b1;
            end else if (sh < -128'sd2147483648) begin
                w[i] = 32'h8000_0000; r.sat = 1'b1;
            end else begin
                w[i] = sh[31:0];
            end
        end
        r.wx = w[0]; r.wy = w[1]; r.wz = w[2];
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t: %s got %h expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    initial mismatches = 0;
    assign pending = world_q.size();

    always @(posedge aclk) begin
        world_t e;
        if (aresetn && s_tvalid && s_tready) begin
            world_q.insert(world_q.size(), predict_world(s_tdata));
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (world_q.size() == 0) begin
                report("unexpected item world_x", m_tdata[31:0], 32'h0);
            end else begin
                e = world_q.pop_front();
                if (m_tdata[31:0] !== e.wx) report("world_x", m_tdata[31:0], e.wx);
                if (m_tdata[63:32] !== e.wy) report("world_y", m_tdata[63:32], e.wy);
                if (m_tdata[95:64] !== e.wz) report("world_z", m_tdata[95:64], e.wz);
                if (m_tuser[0] !== e.sat) report("saturated", 32'(m_tuser[0]), 32'(e.sat));
            end
        end
    end
endmodule

// File: bench/tb_top.sv
// Testbench top that drives the arbitrary axis transform and gives the verdict.
`timescale 1ns / 100ps
module tb_top;
    localparam int IDLE_LIMIT = 3000;
    localparam int ONE = 32'h0001_0000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [95:0]  m_tdata;
    logic [0:0]   m_tuser;
    int           mismatches, pending;
    int           idle_cycles = 0;
    int           burst_left = 4;
    int           stall_mode = 0;
    int           stall_count = 0;

    arbitrary_axis_ocs_to_wcs_unit dut (.*);

    tb_checker checker_i (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        stall_count <= stall_count + 1;
        if (stall_count % 200 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (stall_count % 7) < 2;
            default: m_tready <= ($urandom_range(0, 9) != 0);
        endcase
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_item(input logic [31:0] nx, ny, nz, px, py, pz);
        s_tdata <= {pz, py, px, nz, ny, nx};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
    endtask

    function automatic logic [31:0] rand_field(input int kind);
        case (kind)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2047)) - 1024);
            2: return 32'($signed($urandom_range(0, 262143)) - 131072);
            default: return $urandom_range(0, 1) ? 32'h7fff_ffff - $urandom_range(0, 3)
                                                 : 32'h8000_0000 + $urandom_range(0, 3);
        endcase
    endfunction

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_item(0, 0, 0, ONE, ONE, ONE);
        send_item(0, 0, ONE, ONE, 2 * ONE, 3 * ONE);
        send_item(0, 0, -ONE, ONE, 2 * ONE, 3 * ONE);
        send_item(ONE, 0, 0, 5 * ONE, -ONE, 7 * ONE);
        send_item(0, ONE, 0, 5 * ONE, -ONE, 7 * ONE);
        send_item(1023, 1023, ONE, ONE, ONE, ONE);
        send_item(1024, 0, ONE, ONE, ONE, ONE);
        send_item(-1024, 0, ONE, ONE, ONE, ONE);
        send_item(0, -1023, ONE, ONE, ONE, ONE);
        send_item(0, 1024, ONE, ONE, ONE, ONE);
        send_item(0, 500, 0, ONE, ONE, ONE);
        send_item(0, 0, 1, 3, 5, 7);
        send_item(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_item(0, 0, 32'h8000_0000, 32'h7fff_ffff, 0, 32'h8000_0000);
        send_item(ONE, ONE, ONE, 32'hffff_ffff, 1, 32'h8000);
        send_item(0, 0, ONE, 32'h8000, 32'h8000, 32'hffff_8000);
        send_item(ONE, 0, 0, 0, 0, 32'h7fff_ffff);
        for (int i = 0; i < 400; i++) begin
            int kn, kp;
            kn = $urandom_range(0, 9);
            kp = $urandom_range(0, 9);
            if (i == 200) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (pending != 0) @(posedge aclk);
            end
            send_item(rand_field(kn < 4 ? 1 : kn < 6 ? 2 : kn < 9 ? 0 : 3),
                      rand_field(kn < 4 ? 1 : kn < 6 ? 2 : kn < 9 ? 0 : 3),
                      (kn < 6) ? rand_field(kp < 5 ? 2 : 0) : rand_field(kn == 9 ? 3 : 0),
                      rand_field(kp < 5 ? 2 : kp < 8 ? 0 : 3),
                      rand_field(kp < 5 ? 2 : kp < 8 ? 0 : 3),
                      rand_field(kp < 5 ? 2 : kp < 8 ? 0 : 3));
        end
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
